[src/callback_timer_table_assert.svh]
// Assertion macros for the checker of callback_timer_table.
// Depends on nothing; include guard below.
`ifndef CALLBACK_TIMER_TABLE_ASSERT_SVH
`define CALLBACK_TIMER_TABLE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CTT_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CTT_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`endif

[src/ctt_pkg.sv]
// Package for callback_timer_table: command, status and state codes.
// Depends on nothing.
`default_nettype none
package ctt_pkg;
  localparam int unsigned IdW   = 16;
  localparam int unsigned ArgW  = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned SlotW = 5;

  typedef enum logic [2:0] {
    MODE_ADD     = 3'd0,
    MODE_RESTART = 3'd1,
    MODE_CANCEL  = 3'd2,
    MODE_TICK    = 3'd3,
    MODE_DONE    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_RESTARTED = 3'd2,
    ST_FULL      = 3'd3,
    ST_BLOCKED   = 3'd4,
    ST_CANCELLED = 3'd5,
    ST_DONE      = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_FINAL,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

[src/callback_timer_table.sv]
// Top level of the callback timer table: sequencer, per-slot flags and the
// argument/time stores, one shared subtract/compare unit walking the slots.
// Depends on ctt_pkg and ctt_ram.
//
// Items are handled one at a time through one shared saturating subtract and
// compare unit that looks at one slot per cycle while scanning, pausing while
// a fire item waits for m_tready; tready is high only while idle. An add
// without a live match, a restart, a cancel and a tick with nonzero elapsed
// time walk all SLOTS slots; an add that finds a live match at slot k stops
// there; a completion, an undefined mode and a tick with zero elapsed time
// go from the first scan step straight to the final step. A tick emits a
// fire item for each expired live slot, and a result that waits for m_tready
// holds the block. Argument words are held in a RAM read one slot a cycle
// while scanning.
`default_nettype none
module callback_timer_table #(
  parameter int unsigned SLOTS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // mode[2:0], callback_id[18:3], arg_tag[50:19], time_ms[82:51],
  // elapsed_ms[114:83], slot_in[119:115]
  input  wire logic [119:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // status[2:0], slot[7:3], fired_id[23:8], fired_arg[55:24]
  output logic [55:0]       m_tdata,
  // kind
  output logic              m_tuser,
  output logic              m_tlast
);
  import ctt_pkg::*;
  localparam int unsigned IW = $clog2(SLOTS);

  // flag and id/time storage
  logic [SLOTS-1:0] used, canc, pend;
  logic [IdW-1:0]   eid   [SLOTS];
  logic [TimeW-1:0] etime [SLOTS];

  // latched command
  logic [2:0]       mode;
  logic [IdW-1:0]   cid;
  logic [ArgW-1:0]  carg;
  logic [TimeW-1:0] ctime, cel;
  logic [SlotW-1:0] csl;

  state_t state, state_next;
  logic [IW:0]   idx;
  logic [IW-1:0] ix;
  logic          found;
  logic [IW-1:0] hit;

  // output register
  logic [2:0]       o_status;
  logic [SlotW-1:0] o_slot;
  logic [IdW-1:0]   o_id;
  logic             o_kind, o_last;

  assign ix = idx[IW-1:0];

  // lowest free slot
  logic [IW-1:0] free_ix;
  always_comb begin
    free_ix = '0;
    for (int k = SLOTS - 1; k >= 0; k--)
      if (!used[k]) free_ix = IW'(k);
  end

  // argument RAM, read address follows the scan index
  logic          ram_we;
  logic [IW-1:0] ram_addr;
  logic [ArgW-1:0] ram_rd;
  ctt_ram #(.WIDTH(ArgW), .DEPTH(SLOTS)) u_arg (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(carg), .rdata(ram_rd)
  );

  // shared unit: saturating subtract and match for the current slot
  logic [TimeW-1:0] t_eff, t_new;
  logic             live_m, id_m, expire;
  always_comb begin
    t_eff  = canc[ix] ? '0 : etime[ix];
    t_new  = (t_eff <= cel) ? '0 : t_eff - cel;
    id_m   = used[ix] && (eid[ix] == cid);
    live_m = id_m && !canc[ix];
    expire = used[ix] && (t_new == '0) && !pend[ix];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_SCAN;
      S_SCAN: begin
        if (mode == MODE_TICK && cel != '0 && expire && !canc[ix] && eid[ix] != '0)
          state_next = S_EMIT;
        else if (mode == MODE_ADD && live_m) state_next = S_OUT;
        else if (idx == (IW+1)'(SLOTS - 1) || mode == MODE_DONE || mode > MODE_DONE)
          state_next = S_FINAL;
        else if (mode == MODE_TICK && cel == '0) state_next = S_FINAL;
      end
      S_EMIT:  if (m_tready) state_next = (idx == (IW+1)'(SLOTS)) ? S_FINAL : S_SCAN;
      S_FINAL: state_next = S_OUT;
      S_OUT:   if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_tready = (state == S_IDLE);
    m_tvalid = (state == S_OUT) || (state == S_EMIT);
    m_tdata  = {(o_kind ? ram_rd : {ArgW{1'b0}}), o_id, o_slot, o_status};
    m_tuser  = o_kind;
    m_tlast  = o_last;
    // new entry written at the lowest free slot
    ram_we   = (state == S_FINAL) && (mode == MODE_ADD || mode == MODE_RESTART)
               && !found && !(&used);
    // a waiting fire item keeps its slot addressed so the argument holds
    if (state == S_EMIT) ram_addr = o_slot[IW-1:0];
    else if (ram_we) ram_addr = free_ix;
    else ram_addr = ix;
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      canc  <= '0;
      pend  <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        eid[k]   <= '0;
        etime[k] <= '0;
      end
      idx    <= '0;
      found  <= 1'b0;
      hit    <= '0;
      o_kind <= 1'b0;
      o_last <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          mode  <= s_tdata[2:0];
          cid   <= s_tdata[18:3];
          carg  <= s_tdata[50:19];
          ctime <= s_tdata[82:51];
          cel   <= s_tdata[114:83];
          csl   <= s_tdata[119:115];
          idx   <= '0;
          found <= 1'b0;
          hit   <= '0;
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          unique case (mode)
            MODE_ADD: if (live_m) begin
              o_kind <= 1'b0; o_status <= ST_PRESENT; o_slot <= SlotW'(ix);
              o_id <= '0; o_last <= 1'b1;
            end
            MODE_RESTART: if (live_m) begin
              found <= 1'b1; hit <= ix;
            end
            MODE_CANCEL: if (id_m) begin
              canc[ix] <= 1'b1;
              if (!found) begin found <= 1'b1; hit <= ix; end
            end
            MODE_TICK: if (cel != '0 && used[ix]) begin
              if (expire && (canc[ix] || eid[ix] == '0)) begin
                used[ix] <= 1'b0; canc[ix] <= 1'b0; pend[ix] <= 1'b0;
                eid[ix] <= '0; etime[ix] <= '0;
              end else begin
                etime[ix] <= t_new;
                if (expire) begin
                  pend[ix] <= 1'b1;
                  o_kind <= 1'b1; o_status <= ST_ADDED; o_slot <= SlotW'(ix);
                  o_id <= eid[ix]; o_last <= 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
        S_FINAL: begin
          o_kind <= 1'b0; o_id <= '0; o_last <= 1'b1;
          o_slot <= '0; o_status <= ST_DONE;
          unique case (mode)
            MODE_ADD, MODE_RESTART: begin
              if (found && mode == MODE_RESTART) begin
                o_slot <= SlotW'(hit);
                if (pend[hit]) o_status <= ST_BLOCKED;
                else begin
                  o_status <= ST_RESTARTED; etime[hit] <= ctime;
                end
              end else if (&used) begin
                o_status <= ST_FULL;
              end else begin
                o_status <= ST_ADDED; o_slot <= SlotW'(free_ix);
                used[free_ix] <= 1'b1; canc[free_ix] <= 1'b0;
                pend[free_ix] <= 1'b0; eid[free_ix] <= cid;
                etime[free_ix] <= ctime;
              end
            end
            MODE_CANCEL: begin
              o_status <= ST_CANCELLED; o_slot <= SlotW'(hit);
            end
            MODE_DONE: begin
              o_slot <= csl;
              if (32'(csl) < SLOTS && used[csl[IW-1:0]] && pend[csl[IW-1:0]]) begin
                if (ctime != '0) begin
                  etime[csl[IW-1:0]] <= ctime; pend[csl[IW-1:0]] <= 1'b0;
                end else begin
                  used[csl[IW-1:0]] <= 1'b0; canc[csl[IW-1:0]] <= 1'b0;
                  pend[csl[IW-1:0]] <= 1'b0; eid[csl[IW-1:0]] <= '0;
                  etime[csl[IW-1:0]] <= '0;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/ctt_ram.sv]
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module ctt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // single port, read data registered; a same-cycle write returns the old word
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[src/ctt_checker.sv]
// Port-level checker for callback_timer_table, bound to the top level.
// Depends on callback_timer_table_assert.svh.
`default_nettype none
`include "callback_timer_table_assert.svh"
module ctt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);
  // no new item while a result is offered
  `CTT_ASSERT_IMP(a_excl, clk, rst, m_tvalid, !s_tready, "ready while output valid")
  // fire items never end a run
  `CTT_ASSERT_IMP(a_fire, clk, rst, m_tvalid && m_tuser, !m_tlast, "fire item with last")
  // after an accepted item the block is busy
  `CTT_ASSERT_NEXT(a_busy, clk, rst, s_tvalid && s_tready, !s_tready, "ready after accept")
  // a stalled result stays
  `CTT_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "output dropped")
endmodule
bind callback_timer_table ctt_checker u_ctt_checker (.*);
`default_nettype wire
